@@ src/zobtt_pkg.sv @@
package zobtt_pkg;

  localparam int unsigned GRID_SIZE   = 15;
  localparam int unsigned INDEX_BITS  = 16;
  localparam int unsigned NUM_TABLES  = 2;
  localparam int unsigned PIECE_KINDS = 2;

  localparam int unsigned KEY_SLOTS     = PIECE_KINDS * GRID_SIZE * GRID_SIZE;
  localparam int unsigned TABLE_ENTRIES = 1 << INDEX_BITS;
  localparam int unsigned TOTAL_ENTRIES = NUM_TABLES * TABLE_ENTRIES;

  localparam int unsigned KEY_AW   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned ENTRY_AW = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;

  localparam int unsigned IKEY_W  = 16;
  localparam int unsigned CKEY_W  = 64;
  localparam int unsigned KEY_W   = IKEY_W + CKEY_W;
  localparam int unsigned INFO_W  = 27;
  localparam int unsigned ENTRY_W = CKEY_W + INFO_W;

  typedef enum logic [2:0] {
    REQ_LOAD   = 3'd0,
    REQ_CLEAR  = 3'd1,
    REQ_TOGGLE = 3'd2,
    REQ_PROBE  = 3'd3,
    REQ_STORE  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    BOUND_EXACT = 2'd0,
    BOUND_LOWER = 2'd1,
    BOUND_UPPER = 2'd2
  } bound_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic               piece;
    logic [3:0]         row;
    logic [3:0]         col;
    logic [15:0]        key_index_word;
    logic [63:0]        key_check_word;
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic [7:0]         depth;
    logic               table_sel;
    logic [1:0]         bound_kind;
    logic signed [15:0] score_in;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] score;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic finish;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic need_wait;
    logic sweep_last;
  } status_t;

endpackage

@@ src/zobtt_req_if.sv @@
interface zobtt_req_if;
  logic            valid;
  logic            ready;
  zobtt_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/zobtt_rsp_if.sv @@
interface zobtt_rsp_if;
  logic            valid;
  logic            ready;
  zobtt_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/zobtt_ram.sv @@
module zobtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/zobtt_ctrl.sv @@
module zobtt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  input  zobtt_pkg::status_t  status_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output zobtt_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_SWEEP = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_ready_i);
  assign out_valid_o = (state_q == ST_DONE);
  assign accept      = in_valid_i && in_ready_o;

  assign cmd_o.accept = accept;
  assign cmd_o.finish = (state_q == ST_WAIT);
  assign cmd_o.sweep  = (state_q == ST_SWEEP);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = status_i.need_wait ? ST_WAIT : ST_DONE;
        end
      end
      ST_WAIT: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (accept) begin
          state_d = status_i.need_wait ? ST_WAIT : ST_DONE;
        end else if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/zobtt_datapath.sv @@
module zobtt_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  zobtt_pkg::cmd_t     cmd_i,
  input  zobtt_pkg::req_t     req_i,
  output zobtt_pkg::status_t  status_o,
  output zobtt_pkg::rsp_t     rsp_o
);

  localparam int unsigned KA = zobtt_pkg::KEY_AW;
  localparam int unsigned EA = zobtt_pkg::ENTRY_AW;
  localparam int unsigned IB = zobtt_pkg::INDEX_BITS;
  localparam int unsigned CW = zobtt_pkg::CKEY_W;
  localparam int unsigned IW = zobtt_pkg::IKEY_W;

  logic                    is_load, is_clear, is_toggle, is_probe, is_store;
  logic                    slot_ok, table_ok;
  logic [KA-1:0]           slot;
  logic [IB-1:0]           entry_idx;
  logic [EA-1:0]           entry_addr;

  logic [IW-1:0]           run_idx_q;
  logic [CW-1:0]           run_chk_q;
  logic [EA-1:0]           sweep_cnt_q;

  logic                    toggle_q;
  logic signed [31:0]      alpha_q, beta_q;
  logic [7:0]              depth_q;
  logic                    hit_q;
  logic signed [15:0]      score_q;

  logic                    key_we;
  logic [zobtt_pkg::KEY_W-1:0]   key_rd;
  logic                    entry_we;
  logic [EA-1:0]           entry_waddr;
  logic [zobtt_pkg::ENTRY_W-1:0] entry_wdata, entry_rd;

  logic [CW-1:0]           e_check;
  logic                    e_valid;
  logic [1:0]              e_kind;
  logic [15:0]             e_score;
  logic [7:0]              e_depth;
  logic signed [31:0]      e_score_ext;
  logic                    kind_ok, probe_hit;

  assign is_load   = (req_i.req_type == zobtt_pkg::REQ_LOAD);
  assign is_clear  = (req_i.req_type == zobtt_pkg::REQ_CLEAR);
  assign is_toggle = (req_i.req_type == zobtt_pkg::REQ_TOGGLE);
  assign is_probe  = (req_i.req_type == zobtt_pkg::REQ_PROBE);
  assign is_store  = (req_i.req_type == zobtt_pkg::REQ_STORE);

  assign slot_ok = (32'(req_i.piece) < zobtt_pkg::PIECE_KINDS)
                && (32'(req_i.row) < zobtt_pkg::GRID_SIZE)
                && (32'(req_i.col) < zobtt_pkg::GRID_SIZE);
  assign slot = KA'((32'(req_i.piece) * zobtt_pkg::GRID_SIZE + 32'(req_i.row))
                    * zobtt_pkg::GRID_SIZE + 32'(req_i.col));

  assign table_ok   = (32'(req_i.table_sel) < zobtt_pkg::NUM_TABLES);
  assign entry_idx  = IB'(run_idx_q);
  assign entry_addr = EA'({req_i.table_sel, entry_idx});

  assign status_o.need_wait  = (is_toggle && slot_ok) || (is_probe && table_ok);
  assign status_o.sweep_last = (sweep_cnt_q == EA'(zobtt_pkg::TOTAL_ENTRIES - 1));

  assign key_we = cmd_i.accept && is_load && slot_ok;

  zobtt_ram #(
    .WIDTH (zobtt_pkg::KEY_W),
    .DEPTH (zobtt_pkg::KEY_SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (slot),
    .wdata_i ({req_i.key_index_word, req_i.key_check_word}),
    .raddr_i (slot),
    .rdata_o (key_rd)
  );

  assign entry_we    = cmd_i.sweep || (cmd_i.accept && is_store && table_ok);
  assign entry_waddr = cmd_i.sweep ? sweep_cnt_q : entry_addr;
  assign entry_wdata = cmd_i.sweep ? '0
                     : {run_chk_q, 1'b1, req_i.bound_kind, req_i.score_in, req_i.depth};

  zobtt_ram #(
    .WIDTH (zobtt_pkg::ENTRY_W),
    .DEPTH (zobtt_pkg::TOTAL_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (entry_we),
    .waddr_i (entry_waddr),
    .wdata_i (entry_wdata),
    .raddr_i (entry_addr),
    .rdata_o (entry_rd)
  );

  assign e_check     = entry_rd[90:27];
  assign e_valid     = entry_rd[26];
  assign e_kind      = entry_rd[25:24];
  assign e_score     = entry_rd[23:8];
  assign e_depth     = entry_rd[7:0];
  assign e_score_ext = $signed({{16{e_score[15]}}, e_score});

  always_comb begin
    case (zobtt_pkg::bound_e'(e_kind))
      zobtt_pkg::BOUND_EXACT: kind_ok = 1'b1;
      zobtt_pkg::BOUND_LOWER: kind_ok = (e_score_ext >= beta_q);
      zobtt_pkg::BOUND_UPPER: kind_ok = (e_score_ext <= alpha_q);
      default:                kind_ok = 1'b0;
    endcase
  end

  assign probe_hit = e_valid && (e_depth >= depth_q) && (e_check == run_chk_q) && kind_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_idx_q   <= '0;
      run_chk_q   <= '0;
      sweep_cnt_q <= '0;
    end else begin
      if (cmd_i.sweep) begin
        sweep_cnt_q <= sweep_cnt_q + 1'b1;
      end
      if (cmd_i.accept && is_clear) begin
        run_idx_q <= '0;
        run_chk_q <= '0;
      end else if (cmd_i.finish && toggle_q) begin
        run_idx_q <= run_idx_q ^ key_rd[zobtt_pkg::KEY_W-1:CW];
        run_chk_q <= run_chk_q ^ key_rd[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      toggle_q <= is_toggle;
      alpha_q  <= req_i.alpha;
      beta_q   <= req_i.beta;
      depth_q  <= req_i.depth;
      hit_q    <= 1'b0;
      score_q  <= '0;
    end else if (cmd_i.finish && !toggle_q) begin
      hit_q    <= probe_hit;
      score_q  <= probe_hit ? $signed(e_score) : 16'sd0;
    end
  end

  assign rsp_o.hit   = hit_q;
  assign rsp_o.score = score_q;

endmodule

@@ src/zobrist_transposition_table_unit.sv @@
// Channel   Port   Direction  Payload
// request   req_i  in         req_type, square, keys, window, depth, table, kind, score
// response  rsp_o  out        hit, score
//
// A toggle of a square on the board and a probe pass through a wait state, for the registered
// read of the key memory or the entry memory, and then fold or compare the word.
// Every other item gives its result in the cycle after acceptance.
// A new item is accepted in the same cycle in which the waiting result is taken.
// After reset a clearing pass writes all 131072 entries invalid, one entry a cycle,
// with ready low.
module zobrist_transposition_table_unit (
  input logic         clk_i,
  input logic         rst_ni,
  zobtt_req_if.sink   req_i,
  zobtt_rsp_if.source rsp_o
);

  zobtt_pkg::cmd_t    cmd;
  zobtt_pkg::status_t status;
  zobtt_pkg::rsp_t    rsp;
  logic               in_ready, out_valid;

  zobtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  zobtt_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (req_i.payload),
    .status_o (status),
    .rsp_o    (rsp)
  );

  assign req_i.ready   = in_ready;
  assign rsp_o.valid   = out_valid;
  assign rsp_o.payload = rsp;

endmodule

@@ verif/zobtt_checker.sv @@
module zobtt_checker
  import zobtt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  zobtt_req_if        req_i,
  zobtt_rsp_if        rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned items_o,
  output int unsigned hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CKEY_W-1:0]  check;
    logic [1:0]         kind;
    logic signed [15:0] score;
    logic [7:0]         depth;
  } tt_entry_t;

  logic [IKEY_W-1:0] sq_index_key [KEY_SLOTS];
  logic [CKEY_W-1:0] sq_check_key [KEY_SLOTS];
  logic [IKEY_W-1:0] run_index_key;
  logic [CKEY_W-1:0] run_check_key;
  tt_entry_t         tt_mem [int unsigned];
  rsp_t              pending_lookups [$];
  int unsigned       fail_count;
  int unsigned       item_count;
  int unsigned       hit_count;

  initial begin
    foreach (sq_index_key[i]) begin
      sq_index_key[i] = '0;
      sq_check_key[i] = '0;
    end
    run_index_key = '0;
    run_check_key = '0;
    fail_count    = 0;
    item_count    = 0;
    hit_count     = 0;
    fail_count_o  = 0;
    pending_o     = 0;
    items_o       = 0;
    hits_o        = 0;
  end

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
    fail_count++;
  endtask

  // Updates the key and table state for one item and returns its result.
  function automatic rsp_t apply_request(req_t r);
    rsp_t        res;
    int          slot;
    int unsigned entry;
    tt_entry_t   e;
    res = '0;
    slot = -1;
    if (r.piece < PIECE_KINDS && r.row < GRID_SIZE && r.col < GRID_SIZE) begin
      slot = (int'(r.piece) * GRID_SIZE + r.row) * GRID_SIZE + r.col;
    end
    entry = r.table_sel * TABLE_ENTRIES + (run_index_key & (TABLE_ENTRIES - 1));
    case (r.req_type)
      REQ_LOAD: begin
        if (slot >= 0) begin
          sq_index_key[slot] = r.key_index_word;
          sq_check_key[slot] = r.key_check_word;
        end
      end
      REQ_CLEAR: begin
        run_index_key = '0;
        run_check_key = '0;
      end
      REQ_TOGGLE: begin
        if (slot >= 0) begin
          run_index_key = run_index_key ^ sq_index_key[slot];
          run_check_key = run_check_key ^ sq_check_key[slot];
        end
      end
      REQ_PROBE: begin
        if (r.table_sel < NUM_TABLES && tt_mem.exists(entry)) begin
          e = tt_mem[entry];
          if (e.depth >= r.depth && e.check == run_check_key) begin
            case (e.kind)
              BOUND_EXACT: res.hit = 1'b1;
              BOUND_LOWER: res.hit = ($signed(e.score) >= $signed(r.beta));
              BOUND_UPPER: res.hit = ($signed(e.score) <= $signed(r.alpha));
              default:     res.hit = 1'b0;
            endcase
          end
          if (res.hit) begin
            res.score = e.score;
          end
        end
      end
      REQ_STORE: begin
        if (r.table_sel < NUM_TABLES) begin
          tt_mem[entry] = '{check: run_check_key, kind: r.bound_kind,
                            score: r.score_in, depth: r.depth};
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin : monitor
    rsp_t want;
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch("result with no item outstanding", 64'(0), 64'(rsp_i.payload));
        end else begin
          want = pending_lookups.pop_front();
          if (rsp_i.payload.hit !== want.hit) begin
            report_mismatch("hit", 64'(want.hit), 64'(rsp_i.payload.hit));
          end
          if (rsp_i.payload.score !== want.score) begin
            report_mismatch("score", 64'(want.score), 64'(rsp_i.payload.score));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        want = apply_request(req_i.payload);
        pending_lookups.push_back(want);
        item_count++;
        if (want.hit) begin
          hit_count++;
        end
      end
      pending_o    <= pending_lookups.size();
      fail_count_o <= fail_count;
      items_o      <= item_count;
      hits_o       <= hit_count;
    end
  end

endmodule

@@ verif/tb_zobrist_transposition_table_unit.sv @@
module tb_zobrist_transposition_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import zobtt_pkg::*;

  localparam int unsigned       WATCHDOG_LIMIT  = 400000;
  localparam int unsigned       RANDOM_ITEMS    = 500;
  localparam int unsigned       TAIL_CYCLES     = 8;
  localparam int unsigned       LAST_SLOT       = KEY_SLOTS - 1;
  localparam logic [2:0]        REQ_RESERVED_LO = 3'd5;
  localparam logic [2:0]        REQ_RESERVED_HI = 3'd7;
  localparam logic [1:0]        BOUND_RESERVED  = 2'd3;
  localparam logic signed [31:0] WINDOW_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WINDOW_MIN     = 32'sh8000_0000;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_COIN,
    STALL_THIRD,
    STALL_LONG
  } stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned item_count;
  int unsigned hit_count;
  bit          key_loaded [KEY_SLOTS];
  int unsigned loaded_q [$];
  int unsigned burst_left = 0;
  int unsigned sent_count = 0;
  int unsigned idle_cycles = 0;

  zobtt_req_if req_if ();
  zobtt_rsp_if rsp_if ();

  zobrist_transposition_table_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  zobtt_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .items_o      (item_count),
    .hits_o       (hit_count)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without an accepted item.", idle_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : rsp_stall_pattern
    stall_mode_e mode;
    int unsigned stretch;
    int unsigned tick;
    rsp_if.ready = 1'b0;
    mode = STALL_NONE;
    stretch = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (stretch == 0) begin
        mode = stall_mode_e'($urandom_range(3));
        stretch = $urandom_range(60, 5);
      end
      stretch--;
      tick++;
      case (mode)
        STALL_NONE:  rsp_if.ready <= 1'b1;
        STALL_COIN:  rsp_if.ready <= 1'($urandom_range(1));
        STALL_THIRD: rsp_if.ready <= (tick % 3 == 0);
        default:     rsp_if.ready <= (stretch % 8 == 0);
      endcase
    end
  end

  function automatic req_t random_item(logic [2:0] kind);
    req_t r;
    r.req_type       = kind;
    r.piece          = 1'($urandom_range(1));
    r.row            = 4'($urandom_range(15));
    r.col            = 4'($urandom_range(15));
    r.key_index_word = 16'($urandom);
    r.key_check_word = {$urandom, $urandom};
    r.alpha          = $urandom;
    r.beta           = $urandom;
    r.depth          = 8'($urandom);
    r.table_sel      = 1'($urandom_range(1));
    r.bound_kind     = 2'($urandom_range(3));
    r.score_in       = 16'($urandom);
    return r;
  endfunction

  function automatic req_t square_item(logic [2:0] kind, int unsigned slot);
    req_t r;
    r = random_item(kind);
    r.piece = 1'(slot / (GRID_SIZE * GRID_SIZE));
    r.row   = 4'((slot / GRID_SIZE) % GRID_SIZE);
    r.col   = 4'(slot % GRID_SIZE);
    return r;
  endfunction

  function automatic req_t store_item(logic tbl, logic [1:0] kind, logic signed [15:0] score,
                                      logic [7:0] dep);
    req_t r;
    r = random_item(REQ_STORE);
    r.table_sel  = tbl;
    r.bound_kind = kind;
    r.score_in   = score;
    r.depth      = dep;
    return r;
  endfunction

  function automatic req_t probe_item(logic tbl, logic [7:0] dep, logic signed [31:0] lo,
                                      logic signed [31:0] hi);
    req_t r;
    r = random_item(REQ_PROBE);
    r.table_sel = tbl;
    r.depth     = dep;
    r.alpha     = lo;
    r.beta      = hi;
    return r;
  endfunction

  function automatic int unsigned pick_loaded();
    return loaded_q[$urandom_range(loaded_q.size() - 1)];
  endfunction

  function automatic logic signed [31:0] near_score(logic signed [15:0] s);
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    return int'(s) + int'($urandom_range(4)) - 2;
  endfunction

  // A toggle of a square whose key was never loaded is turned into a load of that square.
  task automatic send_item(req_t item);
    int unsigned slot;
    bit          on_board;
    on_board = item.row < GRID_SIZE && item.col < GRID_SIZE && item.piece < PIECE_KINDS;
    slot = (item.piece * GRID_SIZE + item.row) * GRID_SIZE + item.col;
    if (item.req_type == REQ_TOGGLE && on_board && !key_loaded[slot]) begin
      item.req_type = REQ_LOAD;
    end
    if (item.req_type == REQ_LOAD && on_board && !key_loaded[slot]) begin
      key_loaded[slot] = 1'b1;
      loaded_q.push_back(slot);
    end
    if (on_board || item.req_type inside {REQ_CLEAR, REQ_PROBE, REQ_STORE}) begin
      sent_count++;
    end
    @(negedge clk_i);
    req_if.valid   <= 1'b1;
    req_if.payload <= item;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat ($urandom_range(6)) @(negedge clk_i);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 10) : $urandom_range(3);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    req_t              item;
    int unsigned       start;
    int unsigned       choice;
    int unsigned       slot;
    bit                drained_mid;
    logic              tbl;
    logic [1:0]        kind;
    logic signed [15:0] score;
    logic [7:0]        dep;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    drained_mid    = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    item = square_item(REQ_LOAD, 0);
    item.key_index_word = '1;
    item.key_check_word = '1;
    send_item(item);
    send_item(square_item(REQ_LOAD, LAST_SLOT));
    item = square_item(REQ_LOAD, $urandom_range(LAST_SLOT - 1, 1));
    item.key_index_word = '0;
    item.key_check_word = '0;
    send_item(item);
    item = random_item(REQ_LOAD);
    item.row = 4'hF;
    send_item(item);
    item = random_item(REQ_LOAD);
    item.row = 4'h0;
    item.col = 4'hF;
    send_item(item);
    item = random_item(REQ_TOGGLE);
    item.row = 4'hF;
    item.col = 4'hF;
    send_item(item);
    send_item(square_item(REQ_TOGGLE, 0));
    send_item(store_item(1'b0, BOUND_EXACT, 16'sh7FFF, 8'hFF));
    send_item(probe_item(1'b0, 8'hFF, WINDOW_MIN, WINDOW_MAX));
    send_item(probe_item(1'b1, 8'h00, WINDOW_MIN, WINDOW_MAX));
    send_item(square_item(REQ_TOGGLE, LAST_SLOT));
    send_item(store_item(1'b1, BOUND_LOWER, 16'sh8000, 8'h00));
    send_item(probe_item(1'b1, 8'h00, WINDOW_MAX, WINDOW_MIN));
    send_item(probe_item(1'b1, 8'h01, WINDOW_MAX, WINDOW_MIN));
    send_item(probe_item(1'b1, 8'h00, WINDOW_MAX, -32767));
    send_item(store_item(1'b0, BOUND_UPPER, 16'sd100, 8'd10));
    send_item(probe_item(1'b0, 8'd10, 100, WINDOW_MAX));
    send_item(probe_item(1'b0, 8'd10, 99, WINDOW_MAX));
    send_item(probe_item(1'b0, 8'd0, WINDOW_MAX, WINDOW_MIN));
    send_item(store_item(1'b0, BOUND_RESERVED, 16'sd5, 8'd0));
    send_item(probe_item(1'b0, 8'd0, WINDOW_MAX, WINDOW_MIN));
    send_item(random_item(REQ_CLEAR));
    send_item(probe_item(1'b0, 8'd0, WINDOW_MAX, WINDOW_MIN));
    for (int code = REQ_RESERVED_LO; code <= REQ_RESERVED_HI; code++) begin
      send_item(random_item(3'(code)));
    end
    drain_results();

    // Most random traffic builds a position from loaded keys and then stores and probes it.
    start = sent_count;
    while (sent_count - start < RANDOM_ITEMS) begin
      if (!drained_mid && sent_count - start >= RANDOM_ITEMS / 2) begin
        drain_results();
        drained_mid = 1'b1;
      end
      choice = $urandom_range(99);
      if (choice < 12) begin
        repeat ($urandom_range(3, 1)) begin
          item = square_item(REQ_LOAD, $urandom_range(LAST_SLOT));
          if ($urandom_range(9) == 0) begin
            item.row = 4'($urandom_range(15, GRID_SIZE));
          end
          send_item(item);
        end
      end else if (choice < 27) begin
        send_item(random_item(REQ_CLEAR));
        repeat ($urandom_range(4, 1)) send_item(square_item(REQ_TOGGLE, pick_loaded()));
      end else if (choice < 55) begin
        if ($urandom_range(1)) begin
          send_item(square_item(REQ_TOGGLE, pick_loaded()));
        end
        tbl = 1'($urandom_range(1));
        kind = ($urandom_range(15) == 0) ? BOUND_RESERVED : 2'($urandom_range(2));
        if ($urandom_range(7) == 0) begin
          score = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end else begin
          score = 16'($urandom);
        end
        dep = 8'($urandom);
        send_item(store_item(tbl, kind, score, dep));
        repeat ($urandom_range(3, 1)) begin
          send_item(probe_item(($urandom_range(9) == 0) ? ~tbl : tbl,
                               ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(dep)),
                               near_score(score), near_score(score)));
        end
      end else if (choice < 75) begin
        slot = pick_loaded();
        tbl = 1'($urandom_range(1));
        send_item(square_item(REQ_TOGGLE, slot));
        send_item(probe_item(tbl, 8'($urandom), $urandom, $urandom));
        send_item(square_item(REQ_TOGGLE, slot));
        send_item(probe_item(tbl, 8'd0, WINDOW_MAX, WINDOW_MIN));
      end else if (choice < 90) begin
        send_item(probe_item(1'($urandom_range(1)), 8'($urandom), $urandom, $urandom));
      end else begin
        send_item(random_item(3'($urandom_range(7))));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Checked %0d items, %0d of them probes that found a usable entry.",
             item_count, hit_count);
    $display("Keys loaded for %0d of %0d squares; traffic mixed stores, probes, toggles, clears.",
             loaded_q.size(), KEY_SLOTS);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
